[rtl/sgs_pkg.sv]
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared constants for the sparse group shrinkage block: register indexes
// and the widths of the norm and divide datapaths.
// ----------------------------------------------------------------------------
package sgs_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GROUP_LENGTH      = 2'd0;
    localparam logic [1:0] CFG_GROUP_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_ELEMENT_THRESHOLD = 2'd2;

    // datapath widths
    localparam int SUM_BITS   = 64;
    localparam int ROOT_BITS  = 32;
    localparam int STEP_BITS  = 5;
    localparam logic [STEP_BITS-1:0] LAST_STEP = 5'd31;

    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [ROOT_BITS-1:0] root_t;

endpackage

[rtl/sgs_group_mem.sv]
// ----------------------------------------------------------------------------
// sgs_group_mem
// Group buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgs_group_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered: data follows in the cycle after rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/sgs_isqrt.sv]
// ----------------------------------------------------------------------------
// sgs_isqrt
// Integer square root of a 64-bit sum, one result bit per cycle.
// ----------------------------------------------------------------------------
module sgs_isqrt import sgs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  sum_t  radicand,
    output logic  done,
    output root_t root
);

    logic busy_reg;
    logic done_reg;
    sum_t v_reg;
    sum_t r_reg;
    sum_t bit_reg;
    sum_t trial;
    logic take;

    // trial subtract of the current digit
    always_comb begin
        trial = r_reg + bit_reg;
        take  = v_reg >= trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= sum_t'(1) << (SUM_BITS - 2);
        end else if (busy_reg) begin
            if (take) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_BITS-1:0];

endmodule

[rtl/sgs_divider.sv]
// ----------------------------------------------------------------------------
// sgs_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, quotient known to
// fit 32 bits; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgs_divider import sgs_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  sum_t  dividend,
    input  root_t divisor,
    output logic  done,
    output root_t quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    root_t                rem_reg;
    root_t                dvd_reg;
    root_t                q_reg;
    logic [ROOT_BITS:0]   rem_sh;
    logic                 take;

    // shift in the next dividend bit and compare
    always_comb begin
        rem_sh = {rem_reg, dvd_reg[ROOT_BITS-1]};
        take   = rem_sh >= {1'b0, divisor};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[SUM_BITS-1:ROOT_BITS];
            dvd_reg <= dividend[ROOT_BITS-1:0];
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= take ? ROOT_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[ROOT_BITS-1:0];
            dvd_reg <= dvd_reg << 1;
            q_reg   <= {q_reg[ROOT_BITS-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/sparse_group_shrinkage.sv]
// ----------------------------------------------------------------------------
// sparse_group_shrinkage
// Sparse group lasso shrink on a stream of Q16.16 elements: soft threshold
// per element, group norm, then the group replayed from the buffer scaled.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  input    | s_valid s_ready s_element_value         | in, one word per element
//           | s_group_weight                          |
//  result   | m_valid m_ready m_shrunk_value          | out, one word per element
//           | m_group_done                            |
//  config   | cfg_we cfg_index cfg_data               | in, write only
//
//  elements load at one per cycle while s_ready is high; a group closes with
//  the sum drain, the square root and the division (no division when the
//  factor is not positive), then each result passes the buffer read, the sign
//  and magnitude, and the two partial products of the scaling multiply
//  reset is synchronous and active low; the group buffer is not cleared
//  input is held off while a group is closed and replayed; a stalled result
//  holds the replay in place
// ----------------------------------------------------------------------------
module sparse_group_shrinkage import sgs_pkg::*; #(
    parameter int MAX_GROUP  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_element_value,
    input  logic [31:0]           s_group_weight,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_shrunk_value,
    output logic                  m_group_done,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam int HW = (VALUE_BITS > 16) ? VALUE_BITS - 16 : 1;
    localparam int EW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    typedef enum logic [3:0] {
        S_LOAD, S_DRAIN0, S_DRAIN1, S_ROOT_GO, S_ROOT_WAIT, S_DIV_GO, S_DIV_WAIT,
        S_READ, S_MAG, S_LO, S_HI, S_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [6:0]  group_length_reg;
    logic [31:0] group_threshold_reg;
    logic [31:0] element_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_length_reg      <= 7'd2;
            group_threshold_reg   <= '0;
            element_threshold_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GROUP_LENGTH:      group_length_reg      <= cfg_data[6:0];
                CFG_GROUP_THRESHOLD:   group_threshold_reg   <= cfg_data;
                CFG_ELEMENT_THRESHOLD: element_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // soft threshold of the incoming element
    logic                  in_acc;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic [VALUE_BITS-1:0] in_smag;
    logic [VALUE_BITS-1:0] in_soft;
    logic [LW-1:0]         len_eff;
    logic [LW-1:0]         fill_inc;
    logic                  in_close;
    logic [CW-1:0]         fill_cnt_reg;
    logic [31:0]           held_weight_reg;

    always_comb begin
        in_acc  = s_valid && s_ready;
        in_neg  = s_element_value[VALUE_BITS-1];
        in_mag  = in_neg ? -s_element_value : s_element_value;
        in_smag = (EW'(in_mag) > EW'(element_threshold_reg))
                ? VALUE_BITS'(EW'(in_mag) - EW'(element_threshold_reg)) : '0;
        in_soft = in_neg ? -in_smag : in_smag;
        if (group_length_reg == '0) begin
            len_eff = LW'(1);
        end else if (LW'(group_length_reg) > LW'(MAX_GROUP)) begin
            len_eff = LW'(MAX_GROUP);
        end else begin
            len_eff = LW'(group_length_reg);
        end
        fill_inc = LW'(fill_cnt_reg) + 1'b1;
        in_close = fill_inc >= len_eff;
    end

    assign s_ready = (state_reg == S_LOAD);

    // fill count and weight
    logic [AW-1:0] last_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg    <= '0;
            held_weight_reg <= '0;
        end else if (in_acc) begin
            fill_cnt_reg <= in_close ? '0 : CW'(fill_inc);
            if (fill_cnt_reg == '0) begin
                held_weight_reg <= s_group_weight;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && in_close) begin
            last_idx_reg <= fill_cnt_reg[AW-1:0];
        end
    end

    // square and saturating sum pipeline
    logic [VALUE_BITS-1:0] smag_reg;
    logic                  p1_vld_reg;
    logic                  p1_first_reg;
    sum_t                  sq_reg;
    logic                  p2_vld_reg;
    logic                  p2_first_reg;
    sum_t                  sum_reg;
    logic [SUM_BITS:0]     sum_add;
    logic [31:0]           smag_lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            sum_reg    <= '0;
        end else begin
            p1_vld_reg <= in_acc;
            p2_vld_reg <= p1_vld_reg;
            if (p2_vld_reg) begin
                if (p2_first_reg) begin
                    sum_reg <= sq_reg;
                end else begin
                    sum_reg <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                end
            end
        end
    end

    always_comb begin
        smag_lo = 32'(smag_reg);
        sum_add = {1'b0, sum_reg} + {1'b0, sq_reg};
    end

    always_ff @(posedge aclk) begin
        smag_reg     <= in_smag;
        p1_first_reg <= (fill_cnt_reg == '0);
        p2_first_reg <= p1_first_reg;
        sq_reg       <= ((smag_reg >> 32) != '0) ? '1 : sum_t'(smag_lo) * sum_t'(smag_lo);
    end

    // weight times group threshold
    sum_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= sum_t'(held_weight_reg) * sum_t'(group_threshold_reg);
    end

    // group buffer
    logic                  rd_en;
    logic [AW-1:0]         idx_reg;
    logic [VALUE_BITS-1:0] rd_data;

    assign rd_en = (state_reg == S_READ);

    sgs_group_mem #(
        .DEPTH (MAX_GROUP),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (in_acc),
        .wr_addr (fill_cnt_reg[AW-1:0]),
        .wr_data (in_soft),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // norm and shrink factor
    logic  root_done;
    root_t norm;
    logic  div_done;
    root_t quot;
    logic  keep_now;
    logic  div_start;

    always_comb begin
        keep_now  = (norm != '0) && (prod_reg < (sum_t'(norm) << 16));
        div_start = (state_reg == S_DIV_GO) && keep_now;
    end

    sgs_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_ROOT_GO),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (norm)
    );

    sgs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg << 16),
        .divisor  (norm),
        .done     (div_done),
        .quotient (quot)
    );

    // scaling datapath
    logic                  keep_reg;
    logic                  f_one_reg;
    logic [31:0]           f_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [47:0]           lo_reg;
    logic [48:0]           t_reg;
    logic [HW+31:0]        hi_reg;
    logic [HW+32:0]        u_sum;
    logic [31:0]           res_mag;
    logic [31:0]           res_val;
    logic                  out_load;
    logic                  m_valid_reg;
    logic [31:0]           m_value_reg;
    logic                  m_done_reg;

    always_comb begin
        u_sum = (HW+33)'(hi_reg) + (HW+33)'(t_reg >> 16);
        if (!keep_reg) begin
            res_mag = '0;
        end else if (f_one_reg) begin
            res_mag = 32'(mag_reg);
        end else begin
            res_mag = 32'(u_sum >> 16);
        end
        res_val  = neg_reg ? -res_mag : res_mag;
        out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD: begin
                    if (in_acc && in_close) begin
                        state_reg <= S_DRAIN0;
                    end
                end
                S_DRAIN0:  state_reg <= S_DRAIN1;
                S_DRAIN1:  state_reg <= S_ROOT_GO;
                S_ROOT_GO: state_reg <= S_ROOT_WAIT;
                S_ROOT_WAIT: begin
                    if (root_done) begin
                        state_reg <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    keep_reg  <= keep_now;
                    f_one_reg <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= keep_now ? S_DIV_WAIT : S_READ;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        f_reg     <= -quot;
                        f_one_reg <= (quot == '0);
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_MAG;
                S_MAG: begin
                    neg_reg   <= rd_data[VALUE_BITS-1];
                    mag_reg   <= rd_data[VALUE_BITS-1] ? -rd_data : rd_data;
                    state_reg <= S_LO;
                end
                S_LO: begin
                    lo_reg    <= 48'(mag_reg[15:0]) * 48'(f_reg);
                    state_reg <= S_HI;
                end
                S_HI: begin
                    hi_reg    <= (HW+32)'(HW'(mag_reg >> 16)) * (HW+32)'(f_reg);
                    t_reg     <= 49'(lo_reg) + (49'(1) << 31);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        m_value_reg <= res_val;
                        m_done_reg  <= (idx_reg == last_idx_reg);
                        if (idx_reg == last_idx_reg) begin
                            state_reg <= S_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_shrunk_value = m_value_reg;
    assign m_group_done   = m_done_reg;

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(fill_cnt_reg) < len_eff || LW'(fill_cnt_reg) < LW'(MAX_GROUP))
        else $error("fill count past group bound");

    a_root_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == S_ROOT_WAIT)
        else $error("square root finished outside its wait");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divide finished outside its wait");

    a_close_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && in_close) |=> state_reg == S_DRAIN0 ##2 !p2_vld_reg)
        else $error("sum pipeline not drained before root");

    a_last_word_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && idx_reg == last_idx_reg) |=> s_ready && m_group_done)
        else $error("last word did not release the input");

endmodule

[verif/sparse_group_shrinkage_tb.sv]
// ----------------------------------------------------------------------------
// sparse_group_shrinkage_tb
// Drives element words in groups, predicts the shrunk group in a scoreboard
// class and checks every result word in order, across several register
// settings including length extremes, zero and saturating thresholds.
// ----------------------------------------------------------------------------
module sparse_group_shrinkage_tb;
    import sgs_pkg::*;

    localparam int MAXG = 64;
    localparam int LIMIT_CYCLES = 3000000;

    // ------------------------------------------------------------------
    // scoreboard: group predictor and queue of expected result words
    // ------------------------------------------------------------------
    class shrink_scoreboard;
        logic [6:0]  len_reg = 7'd2;
        logic [31:0] gthr = '0;
        logic [31:0] ethr = '0;
        logic signed [63:0] grp_buf [MAXG];
        int unsigned fill = 0;
        logic [63:0] sq_sum = '0;
        logic [31:0] weight = '0;
        logic [31:0] exp_value [$];
        logic        exp_done [$];
        int errors = 0;
        int words_seen = 0;
        int groups_seen = 0;
        int zero_groups = 0;

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                CFG_GROUP_LENGTH:      len_reg = d[6:0];
                CFG_GROUP_THRESHOLD:   gthr = d;
                CFG_ELEMENT_THRESHOLD: ethr = d;
                default: ;
            endcase
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // note an accepted input word, close the group when full
        function void note_input(logic [31:0] x, logic [31:0] w);
            logic neg, keep;
            logic [63:0] mag, smag, sq, norm, prod, f, m, r;
            logic [127:0] wide;
            int unsigned len;
            neg = x[31];
            mag = neg ? {32'd0, -x} : {32'd0, x};
            if (neg && x[30:0] == 0) mag = 64'h8000_0000;
            smag = (mag > {32'd0, ethr}) ? mag - {32'd0, ethr} : 64'd0;
            if (fill == 0) begin
                weight = w;
                sq_sum = 0;
            end
            grp_buf[fill] = neg ? -$signed(smag) : $signed(smag);
            sq = (smag > 64'hFFFF_FFFF) ? '1 : smag * smag;
            sq_sum = (sq_sum > ~sq) ? '1 : sq_sum + sq;
            fill++;
            len = (len_reg == 0) ? 1 : ((len_reg > MAXG) ? MAXG : len_reg);
            if (fill < len) return;
            norm = int_sqrt(sq_sum);
            prod = {32'd0, weight} * {32'd0, gthr};
            wide = {64'd0, norm} << 16;
            keep = (norm != 0) && ({64'd0, prod} < wide);
            f = 0;
            if (keep) f = (64'd1 << 32) - ((({64'd0, prod} << 16) / norm));
            groups_seen++;
            if (!keep) zero_groups++;
            for (int k = 0; k < fill; k++) begin
                r = 0;
                if (keep) begin
                    m = grp_buf[k] < 0 ? -grp_buf[k] : grp_buf[k];
                    if (f == (64'd1 << 32)) r = m;
                    else begin
                        wide = {64'd0, m} * {64'd0, f} + (128'd1 << 31);
                        r = wide[95:32];
                    end
                    if (grp_buf[k] < 0) r = -r;
                end
                exp_value.push_back(r[31:0]);
                exp_done.push_back(k + 1 == fill);
            end
            fill = 0;
            sq_sum = 0;
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(logic [31:0] v, logic d);
            logic [31:0] ev;
            logic ed;
            words_seen++;
            if (exp_value.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h done %b", v, d);
                return;
            end
            ev = exp_value.pop_front();
            ed = exp_done.pop_front();
            if (ev !== v || ed !== d) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: value exp %h got %h, done exp %b got %b",
                             ev, v, ed, d);
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [31:0] s_element_value = '0, s_group_weight = '0;
    logic m_valid, m_ready = 0;
    logic [31:0] m_shrunk_value;
    logic m_group_done;
    logic cfg_we = 0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int cycles = 0;
    shrink_scoreboard sb = new();

    sparse_group_shrinkage #(.MAX_GROUP(MAXG), .VALUE_BITS(32)) i_dut (.*);

    // clock and cycle limit
    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall, check on accept
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_shrunk_value, m_group_done);
        m_ready <= ($urandom_range(0, 60) != 0)
                && ((cycles % 2000 < 300) || ($urandom_range(0, 9) < 7));
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [31:0] x, logic [31:0] w);
        s_valid <= 1'b1;
        s_element_value <= x;
        s_group_weight <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(x, w);
        if ((cycles % 3000) < 400) return;
        for (int g = gap_len(); g > 0; g--) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.exp_value.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        sb.set_reg(idx, d);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r < 5) return $urandom();
        return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endfunction

    task automatic random_groups(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            send_word(rand_elem(), ($urandom_range(0, 3) == 0) ? $urandom()
                                     : $urandom_range(0, 32'h0002_0000));
            sent++;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: reset defaults, extremes and zero norm
        send_word(32'h7FFF_FFFF, 32'h0001_0000);
        send_word(32'h8000_0000, 32'h0001_0000);
        send_word(32'h0, 32'hFFFF_FFFF);
        send_word(32'h0, 32'h0);
        drain();
        write_reg(CFG_GROUP_THRESHOLD, 32'h0000_8000);
        write_reg(CFG_ELEMENT_THRESHOLD, 32'h0000_4000);
        write_reg(CFG_GROUP_LENGTH, 7'd4);
        send_word(32'h0001_0000, 32'h0001_0000);
        send_word(32'hFFFF_0000, 32'h0);
        send_word(32'h0000_2000, 32'h0);
        send_word(32'h0003_0000, 32'h0);
        send_word(32'h0, 32'hFFFF_FFFF);
        send_word(32'h0001_0000, 32'h0);
        send_word(32'h0, 32'h0);
        send_word(32'h0, 32'h0);
        drain();
        // length zero acts as one, too large acts as max
        write_reg(CFG_GROUP_LENGTH, 7'd0);
        send_word(32'h0005_0000, 32'h0001_0000);
        send_word(32'hFFFB_0000, 32'h0);
        drain();
        write_reg(CFG_GROUP_LENGTH, 7'd127);
        write_reg(CFG_ELEMENT_THRESHOLD, 32'h0);
        write_reg(CFG_GROUP_THRESHOLD, 32'hFFFF_FFFF);
        for (int i = 0; i < MAXG; i++) send_word(rand_elem(), 32'h0000_0001);
        drain();
        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_GROUP_LENGTH, (ph == 7) ? 7'd64 : $urandom_range(1, 8));
            write_reg(CFG_GROUP_THRESHOLD, (ph == 3) ? 32'hFFFF_FFFF
                                                     : $urandom_range(0, 32'h0004_0000));
            write_reg(CFG_ELEMENT_THRESHOLD, (ph == 5) ? 32'hFFFF_FFFF
                                    : ((ph % 2) ? $urandom_range(0, 32'h0002_0000) : 0));
            random_groups((ph == 7) ? 64 : 40);
            drain();
        end
        $display("covered %0d groups (%0d zeroed), %0d result words checked",
                 sb.groups_seen, sb.zero_groups, sb.words_seen);
        if (sb.errors == 0 && sb.exp_value.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d words left", sb.errors, sb.exp_value.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
